>>> hw/rtl/ghaef_pkg.sv
package ghaef_pkg;

   localparam int SampleWidth = 20;
   localparam int SumWidth = 28;
   localparam int MagWidth = 27;
   localparam int CountWidth = 9;
   localparam int RemWidth = 8;
   localparam int AlphaWidth = 17;
   localparam int DiffWidth = 21;
   localparam int ProdWidth = 23;
   localparam int StepWidth = 5;
   localparam int IndexWidth = 2;

   localparam logic [CountWidth-1:0] MAX_WINDOW = 9'd256;
   localparam logic [CountWidth-1:0] LENGTH_RESET = 9'd16;
   localparam logic [AlphaWidth-1:0] ALPHA_ONE = 17'd65536;
   localparam logic [AlphaWidth-1:0] ALPHA_RESET = 17'd6554;
   localparam logic signed [SampleWidth-1:0] GLITCH_FLOOR = -20'sd16;

   localparam logic [StepWidth-1:0] DIV_LAST_STEP = 5'd26;
   localparam logic [StepWidth-1:0] MUL_LAST_STEP = 5'd16;

   localparam logic [IndexWidth-1:0] REG_WINDOW_LENGTH = 2'd0;
   localparam logic [IndexWidth-1:0] REG_SMOOTHING_ALPHA = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_MEAN,
      ST_PREP,
      ST_MUL,
      ST_WRITE
   } state_type;

endpackage

>>> hw/rtl/glitch_hold_average_ema_filter_core.sv
// Windowed power averager with glitch hold and exponential smoothing.
// The req channel carries one power sample per word (signed, 1/16 mW units).
// A sample below -1 mW is replaced by the last good sample of the window.
// When the configured number of samples has been taken, one word leaves on
// the rsp channel with the window mean and the updated smoothed value.
// The csr channel writes window_length (index 0) and smoothing_alpha
// (index 1); other indexes are ignored. It is always ready and should only
// be written while the block is idle.
// A sample that does not close a window is taken and the block stays ready
// for the next. A closing sample has its result word offered once the steps
// below are done; the first window skips the multiplier. A restoring divider
// retires one quotient bit per cycle, a shift-and-add multiplier consumes
// one alpha bit per cycle, and four steps load, check, prepare and write.
// No sample is accepted until that word has been loaded
// into the output register. If the receiver stalls, the word stays there and
// samples are still taken; a later window then waits in its final step with
// req_ready low. Reset is synchronous and restores the register defaults,
// clears the window and marks the filter as awaiting its first window.
module glitch_hold_average_ema_filter_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [ghaef_pkg::SampleWidth-1:0] req_power_sample,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [ghaef_pkg::SampleWidth-1:0] rsp_window_average,
   output logic signed [ghaef_pkg::SampleWidth-1:0] rsp_smoothed_power,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [ghaef_pkg::IndexWidth-1:0] csr_index,
   input  logic [ghaef_pkg::AlphaWidth-1:0] csr_data
);

   ghaef_pkg::state_type state_ff, state_in;

   logic [ghaef_pkg::CountWidth-1:0] window_length_ff;
   logic [ghaef_pkg::AlphaWidth-1:0] smoothing_alpha_ff;

   logic signed [ghaef_pkg::SumWidth-1:0] sum_ff, sum_in;
   logic [ghaef_pkg::CountWidth-1:0] count_ff, count_in;
   logic signed [ghaef_pkg::SampleWidth-1:0] last_good_ff, last_good_in;
   logic signed [ghaef_pkg::SampleWidth-1:0] smoothed_ff, smoothed_in;
   logic first_ff, first_in;

   logic [ghaef_pkg::MagWidth-1:0] quot_ff, quot_in;
   logic [ghaef_pkg::RemWidth-1:0] rem_ff, rem_in;
   logic [ghaef_pkg::CountWidth-1:0] divisor_ff, divisor_in;
   logic neg_ff, neg_in;
   logic [ghaef_pkg::StepWidth-1:0] step_ff, step_in;

   logic signed [ghaef_pkg::SampleWidth-1:0] mean_ff, mean_in;
   logic signed [ghaef_pkg::DiffWidth-1:0] diff_ff, diff_in;
   logic signed [ghaef_pkg::ProdWidth-1:0] prod_ff, prod_in;
   logic [ghaef_pkg::AlphaWidth-1:0] alpha_sr_ff, alpha_sr_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [ghaef_pkg::SampleWidth-1:0] rsp_average_ff, rsp_average_in;
   logic signed [ghaef_pkg::SampleWidth-1:0] rsp_filtered_ff, rsp_filtered_in;

   logic [ghaef_pkg::CountWidth-1:0] length_eff;
   logic [ghaef_pkg::AlphaWidth-1:0] alpha_eff;
   logic signed [ghaef_pkg::SampleWidth-1:0] sample_eff;
   logic [ghaef_pkg::CountWidth-1:0] count_inc;
   logic [ghaef_pkg::CountWidth-1:0] rem_shift;
   logic [ghaef_pkg::SampleWidth-1:0] quot_low;
   logic signed [ghaef_pkg::SampleWidth-1:0] mean_signed;
   logic signed [ghaef_pkg::ProdWidth-1:0] prod_sum;

   assign length_eff = (window_length_ff == '0) ? ghaef_pkg::CountWidth'(1) :
                       (window_length_ff > ghaef_pkg::MAX_WINDOW) ? ghaef_pkg::MAX_WINDOW :
                       window_length_ff;
   assign alpha_eff = (smoothing_alpha_ff > ghaef_pkg::ALPHA_ONE) ? ghaef_pkg::ALPHA_ONE :
                      smoothing_alpha_ff;

   assign sample_eff = (req_power_sample < ghaef_pkg::GLITCH_FLOOR) ? last_good_ff :
                       req_power_sample;
   assign count_inc = count_ff + ghaef_pkg::CountWidth'(1);

   assign rem_shift = {rem_ff, quot_ff[ghaef_pkg::MagWidth-1]};
   assign quot_low = quot_ff[ghaef_pkg::SampleWidth-1:0];
   assign mean_signed = neg_ff ? -$signed(quot_low) : $signed(quot_low);

   assign prod_sum = prod_ff + (alpha_sr_ff[0] ?
                     {{(ghaef_pkg::ProdWidth-ghaef_pkg::DiffWidth)
                       {diff_ff[ghaef_pkg::DiffWidth-1]}}, diff_ff} :
                     ghaef_pkg::ProdWidth'(0));

   assign req_ready = (state_ff == ghaef_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_window_average = rsp_average_ff;
   assign rsp_smoothed_power = rsp_filtered_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ghaef_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sum_in = sum_ff;
      count_in = count_ff;
      last_good_in = last_good_ff;
      smoothed_in = smoothed_ff;
      first_in = first_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      divisor_in = divisor_ff;
      neg_in = neg_ff;
      step_in = step_ff;
      mean_in = mean_ff;
      diff_in = diff_ff;
      prod_in = prod_ff;
      alpha_sr_in = alpha_sr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_average_in = rsp_average_ff;
      rsp_filtered_in = rsp_filtered_ff;
      case (state_ff)
         ghaef_pkg::ST_IDLE: begin
            if (req_valid) begin
               last_good_in = sample_eff;
               sum_in = sum_ff + {{(ghaef_pkg::SumWidth-ghaef_pkg::SampleWidth)
                                   {sample_eff[ghaef_pkg::SampleWidth-1]}}, sample_eff};
               count_in = count_inc;
               if (count_inc >= length_eff) begin
                  last_good_in = '0;
                  state_in = ghaef_pkg::ST_LOAD;
               end
            end
         end
         ghaef_pkg::ST_LOAD: begin
            neg_in = sum_ff[ghaef_pkg::SumWidth-1];
            quot_in = sum_ff[ghaef_pkg::SumWidth-1] ?
                      ghaef_pkg::MagWidth'(-sum_ff) : sum_ff[ghaef_pkg::MagWidth-1:0];
            rem_in = '0;
            divisor_in = count_ff;
            step_in = '0;
            sum_in = '0;
            count_in = '0;
            state_in = ghaef_pkg::ST_DIV;
         end
         ghaef_pkg::ST_DIV: begin
            if (rem_shift >= divisor_ff) begin
               rem_in = ghaef_pkg::RemWidth'(rem_shift - divisor_ff);
               quot_in = {quot_ff[ghaef_pkg::MagWidth-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[ghaef_pkg::RemWidth-1:0];
               quot_in = {quot_ff[ghaef_pkg::MagWidth-2:0], 1'b0};
            end
            step_in = step_ff + ghaef_pkg::StepWidth'(1);
            if (step_ff == ghaef_pkg::DIV_LAST_STEP) begin
               state_in = ghaef_pkg::ST_MEAN;
            end
         end
         ghaef_pkg::ST_MEAN: begin
            mean_in = (mean_signed < ghaef_pkg::GLITCH_FLOOR) ? smoothed_ff : mean_signed;
            state_in = ghaef_pkg::ST_PREP;
         end
         ghaef_pkg::ST_PREP: begin
            diff_in = {mean_ff[ghaef_pkg::SampleWidth-1], mean_ff} -
                      {smoothed_ff[ghaef_pkg::SampleWidth-1], smoothed_ff};
            alpha_sr_in = alpha_eff;
            prod_in = '0;
            step_in = '0;
            state_in = first_ff ? ghaef_pkg::ST_WRITE : ghaef_pkg::ST_MUL;
         end
         ghaef_pkg::ST_MUL: begin
            alpha_sr_in = {1'b0, alpha_sr_ff[ghaef_pkg::AlphaWidth-1:1]};
            step_in = step_ff + ghaef_pkg::StepWidth'(1);
            if (step_ff == ghaef_pkg::MUL_LAST_STEP) begin
               prod_in = prod_sum;
               state_in = ghaef_pkg::ST_WRITE;
            end else begin
               prod_in = prod_sum >>> 1;
            end
         end
         ghaef_pkg::ST_WRITE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (first_ff) begin
                  smoothed_in = mean_ff;
                  rsp_filtered_in = mean_ff;
               end else begin
                  smoothed_in = smoothed_ff + prod_ff[ghaef_pkg::SampleWidth-1:0];
                  rsp_filtered_in = smoothed_ff + prod_ff[ghaef_pkg::SampleWidth-1:0];
               end
               first_in = 1'b0;
               rsp_average_in = mean_ff;
               rsp_valid_in = 1'b1;
               state_in = ghaef_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ghaef_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= ghaef_pkg::LENGTH_RESET;
         smoothing_alpha_ff <= ghaef_pkg::ALPHA_RESET;
         sum_ff <= '0;
         count_ff <= '0;
         last_good_ff <= '0;
         smoothed_ff <= '0;
         first_ff <= 1'b1;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == ghaef_pkg::REG_WINDOW_LENGTH) begin
               window_length_ff <= csr_data[ghaef_pkg::CountWidth-1:0];
            end else if (csr_index == ghaef_pkg::REG_SMOOTHING_ALPHA) begin
               smoothing_alpha_ff <= csr_data;
            end
         end
         sum_ff <= sum_in;
         count_ff <= count_in;
         last_good_ff <= last_good_in;
         smoothed_ff <= smoothed_in;
         first_ff <= first_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      divisor_ff <= divisor_in;
      neg_ff <= neg_in;
      mean_ff <= mean_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      alpha_sr_ff <= alpha_sr_in;
      rsp_average_ff <= rsp_average_in;
      rsp_filtered_ff <= rsp_filtered_in;
   end

endmodule
